FILE: sv/ght_pkg.sv
// Shared types and constants for the generational handle table.
// No dependencies; imported by every ght module and the top level.
package ght_pkg;

    localparam int SLOTS      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int GEN_WIDTH  = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int COUNT_W    = $clog2(SLOTS + 1);
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;

    // command codes on the input port
    localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET_REF  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_VALIDATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_ERASE,
        OP_GET_REF,
        OP_VALIDATE,
        OP_WRITE,
        OP_READ,
        OP_NOP
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOT_LIVE = 2'd2
    } t_status;

    // decoded command as it travels from front to back
    typedef struct packed {
        t_op                   op;
        logic [SLOT_W-1:0]     slot;
        logic [GEN_WIDTH-1:0]  gen;
        logic [DATA_WIDTH-1:0] value;
    } t_cmd_item;

    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic [GEN_WIDTH-1:0]  gen;
        logic [DATA_WIDTH-1:0] data;
        logic                  valid;
        t_status               status;
        logic [COUNT_W-1:0]    count;
    } t_result;

endpackage

FILE: sv/ght_front.sv
// Front end: accepts command beats, decodes them and buffers them in a
// two-entry queue for the back end. Depends on ght_pkg.
module ght_front
    import ght_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [GEN_WIDTH-1:0]  i_gen_in,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_item_valid,
    output t_cmd_item             o_item,
    input  logic                  i_item_take
);

    t_cmd_item   r_q [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    t_cmd_item   n_item;
    logic        accept;

    always_comb begin
        n_item.slot  = i_slot;
        n_item.gen   = i_gen_in;
        n_item.value = i_value;
        unique case (i_cmd)
            CMD_CREATE:   n_item.op = OP_CREATE;
            CMD_ERASE:    n_item.op = OP_ERASE;
            CMD_GET_REF:  n_item.op = OP_GET_REF;
            CMD_VALIDATE: n_item.op = OP_VALIDATE;
            CMD_WRITE:    n_item.op = OP_WRITE;
            CMD_READ:     n_item.op = OP_READ;
            default:      n_item.op = OP_NOP;
        endcase
    end

    assign full         = (r_count == 2'd2);
    assign accept       = push && !full;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_item_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({accept, i_item_take})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/ght_back.sv
// Back end: live flags, generation and data memories, live total.
// Reads a slot, then updates it and emits one result. Depends on ght_pkg.
module ght_back
    import ght_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_item_valid,
    input  t_cmd_item i_item,
    output logic      o_item_take,
    output logic      o_res_push,
    output t_result   o_res,
    input  logic      i_res_full
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                r_state;
    t_cmd_item             r_item;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_found;
    logic [SLOTS-1:0]      r_live;
    logic [SLOTS-1:0]      r_gen_ok;   // generation entry has been written
    logic [SLOTS-1:0]      r_data_ok;  // data entry holds a written word
    logic [COUNT_W-1:0]    r_total;

    logic [GEN_WIDTH-1:0]  mem_gen  [SLOTS];
    logic [DATA_WIDTH-1:0] mem_data [SLOTS];
    logic [GEN_WIDTH-1:0]  r_gen_rd;
    logic [DATA_WIDTH-1:0] r_data_rd;

    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_W-1:0]     tgt;
    logic                  start, finish;
    logic                  gen_we, data_we;
    logic [GEN_WIDTH-1:0]  gen_cur, gen_new;
    logic [DATA_WIDTH-1:0] data_cur;
    logic                  live_cur;
    t_result               res;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_live[k]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
    end

    assign tgt         = (i_item.op == OP_CREATE) ? free_idx : i_item.slot;
    assign start       = (r_state == S_IDLE) && i_item_valid;
    assign finish      = (r_state == S_EXEC) && !i_res_full;
    assign o_item_take = start;

    assign live_cur = r_live[r_slot];
    assign gen_cur  = r_gen_ok[r_slot] ? r_gen_rd : '0;
    assign data_cur = r_data_ok[r_slot] ? r_data_rd : '0;
    assign gen_new  = gen_cur + GEN_WIDTH'(1);
    assign gen_we   = finish && (r_item.op == OP_CREATE) && r_found;
    assign data_we  = finish && (r_item.op == OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_gen_rd  <= mem_gen[tgt];
            r_data_rd <= mem_data[tgt];
        end
        if (gen_we) begin
            mem_gen[r_slot] <= gen_new;
        end
        if (data_we) begin
            mem_data[r_slot] <= r_item.value;
        end
    end

    always_comb begin
        res.slot   = r_slot;
        res.gen    = gen_cur;
        res.data   = data_cur;
        res.valid  = 1'b0;
        res.status = STAT_OK;
        res.count  = r_total;
        unique case (r_item.op)
            OP_CREATE: begin
                if (r_found) begin
                    res.gen   = gen_new;
                    res.data  = '0;
                    res.count = r_total + COUNT_W'(1);
                end else begin
                    res.slot   = '0;
                    res.gen    = '0;
                    res.data   = '0;
                    res.status = STAT_FULL;
                end
            end
            OP_ERASE: begin
                res.data = '0;
                if (live_cur) begin
                    res.count = r_total - COUNT_W'(1);
                end else begin
                    res.status = STAT_NOT_LIVE;
                end
            end
            OP_VALIDATE: res.valid = live_cur && (gen_cur == r_item.gen);
            OP_WRITE:    res.data  = r_item.value;
            OP_GET_REF, OP_READ, OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    assign o_res      = res;
    assign o_res_push = finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_gen_ok  <= '0;
            r_data_ok <= '0;
            r_total   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item  <= i_item;
                        r_slot  <= tgt;
                        r_found <= free_found;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (finish) begin
                        r_total <= res.count;
                        unique case (r_item.op)
                            OP_CREATE: begin
                                if (r_found) begin
                                    r_live[r_slot]    <= 1'b1;
                                    r_gen_ok[r_slot]  <= 1'b1;
                                    r_data_ok[r_slot] <= 1'b0;
                                end
                            end
                            OP_ERASE: begin
                                r_live[r_slot]    <= 1'b0;
                                r_data_ok[r_slot] <= 1'b0;
                            end
                            OP_WRITE: r_data_ok[r_slot] <= 1'b1;
                            default: begin
                            end
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/ght_res_q.sv
// Two-entry result queue presenting empty/pop to the consumer.
// Depends on ght_pkg.
module ght_res_q
    import ght_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_push,
    input  t_result i_res,
    output logic    o_res_full,
    output logic    empty,
    input  logic    pop,
    output t_result o_head
);

    t_result    r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_pop;

    assign o_res_full = (r_count == 2'd2);
    assign empty      = (r_count == 2'd0);
    assign do_pop     = pop && !empty;
    assign o_head     = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_res_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_res_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_res_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/generational_handle_table.sv
// Generational handle table: create/erase/get_ref/validate/write/read on 64 slots.
// A command beat accepted into the front queue is taken by the back end, read, then updated and pushed
// into the result queue (empty low); the back end handles one command at a time while the front queues more.
// Reset (synchronous, active low) clears live flags, written marks and the live total
// at once; no clearing pass, commands are accepted as soon as reset is released.
// Depends on ght_pkg, ght_front, ght_back, ght_res_q.
module generational_handle_table
    import ght_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command side
    input  logic                  push,
    output logic                  full,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [GEN_WIDTH-1:0]  i_gen_in,
    input  logic [DATA_WIDTH-1:0] i_value,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic [SLOT_W-1:0]     o_slot_out,
    output logic [GEN_WIDTH-1:0]  o_gen_out,
    output logic [DATA_WIDTH-1:0] o_data_out,
    output logic                  o_valid_res,
    output logic [STATUS_W-1:0]   o_status,
    output logic [COUNT_W-1:0]    o_live_count
);

    // front -> back command queue handoff
    logic      item_valid;
    logic      item_take;
    t_cmd_item item;

    // back -> result queue
    logic      res_push;
    logic      res_full;
    t_result   res;
    t_result   head;

    // Front: decodes the command code (unused codes become a no-op) and
    // buffers up to two beats so the producer is not held by the back end.
    ght_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_slot       (i_slot),
        .i_gen_in     (i_gen_in),
        .i_value      (i_value),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_take  (item_take)
    );

    // Back: one command at a time. The idle state picks the slot (lowest free
    // for create) and reads its memories; the exec state then updates state and
    // emits the result, waiting there while the result queue is full.
    ght_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .o_res_push   (res_push),
        .o_res        (res),
        .i_res_full   (res_full)
    );

    // Result queue decouples the consumer's pop from the back end.
    ght_res_q u_res_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (res_push),
        .i_res      (res),
        .o_res_full (res_full),
        .empty      (empty),
        .pop        (pop),
        .o_head     (head)
    );

    assign o_slot_out   = head.slot;
    assign o_gen_out    = head.gen;
    assign o_data_out   = head.data;
    assign o_valid_res  = head.valid;
    assign o_status     = head.status;
    assign o_live_count = head.count;

endmodule
